// ----- rtl/stamp_matched_frame_history_unit_defines.svh -----
// Assertion macros for the stamp-matched frame history unit.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef STAMP_MATCHED_FRAME_HISTORY_UNIT_DEFINES_SVH
`define STAMP_MATCHED_FRAME_HISTORY_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define SMFH_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset
`define SMFH_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/smfh_pkg.sv -----
// Shared types and constants for the stamp-matched frame history unit.
// No dependencies.
package smfh_pkg;

   localparam int STAMP_W = 63;
   localparam int TAG_W   = 16;
   localparam int MODE_W  = 2;
   localparam int LIMIT_W = 9;
   localparam int CSR_IDX_W = 2;

   localparam int REQ_DATA_W = 88;  // mode + stamp + tag = 81, padded to bytes
   localparam int RSP_DATA_W = 80;  // found + tag + stamp

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TOLERANCE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LIMIT     = 2'd2;

   // register reset values
   localparam logic [STAMP_W-1:0] WINDOW_RESET    = 63'd1000000000;
   localparam logic [STAMP_W-1:0] TOLERANCE_RESET = 63'd50000000;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET     = 9'd0;

   typedef enum logic [MODE_W-1:0] {
      MODE_PUSH   = 2'd0,
      MODE_NEAR   = 2'd1,
      MODE_BEFORE = 2'd2,
      MODE_NONE   = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_TRIM,
      ST_SCAN,
      ST_FINISH
   } state_type;

   // chain control: rotate every cell by one, and/or load one cell
   typedef struct packed {
      logic shift;
      logic load;
   } cell_ctrl_type;

endpackage

// ----- rtl/stamp_matched_frame_history_unit.sv -----
// Top level of the stamp-matched frame history unit: control, scan and ports.
// Depends on smfh_pkg, smfh_chain, smfh_cell and the assertion macro header.
//
//   channel  direction  handshake                 payload (low bit first)
//   req      in         req_tvalid/req_tready     mode, stamp_ns, frame_tag
//   rsp      out        rsp_tvalid/rsp_tready     found, match_tag, match_stamp_ns
//   csr      in         csr_we (no wait)          history window, tolerance, limit
//
// A push stores the entry, then drops aged or over-limit entries one at a time, then settles.
// A query makes the cell ring rotate one entry per cycle past the compare logic
// at cell 0, a full turn per query.
// Mode 3 is accepted and leaves the store unchanged.
// Reset is synchronous and empties the store; it needs no clearing pass.
// A waiting result sits in the output register; a query that finishes behind it
// stalls in its last cycle until the waiting result is taken.
module stamp_matched_frame_history_unit #(
   parameter int DEPTH = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [1:0] mode, [64:2] stamp_ns, [80:65] frame_tag, [87:81] zero
   input  logic [smfh_pkg::REQ_DATA_W-1:0]   req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [0] found, [16:1] match_tag, [79:17] match_stamp_ns
   output logic [smfh_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  logic                              csr_we,
   input  logic [smfh_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [smfh_pkg::STAMP_W-1:0]      csr_wdata
);
   import smfh_pkg::*;
   `include "stamp_matched_frame_history_unit_defines.svh"

   localparam int IDXW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNTW = $clog2(DEPTH + 1);
   localparam logic [IDXW-1:0]    LAST_IDX  = IDXW'(DEPTH - 1);
   localparam logic [CNTW-1:0]    FULL_CNT  = CNTW'(DEPTH);
   localparam logic [LIMIT_W-1:0] DEPTH_LIM = LIMIT_W'(DEPTH);

   // request fields
   mode_type           req_mode;
   logic [STAMP_W-1:0] req_stamp;
   logic [TAG_W-1:0]   req_tag;
   logic               req_accept;

   assign req_mode   = mode_type'(req_tdata[1:0]);
   assign req_stamp  = req_tdata[64:2];
   assign req_tag    = req_tdata[80:65];
   assign req_accept = req_tvalid && req_tready;

   // registers
   state_type          state_ff, state_in;
   logic [STAMP_W-1:0] window_ff, tolerance_ff;
   logic [LIMIT_W-1:0] limit_ff;
   logic [CNTW-1:0]    count_ff, count_in;
   logic [IDXW-1:0]    scan_idx_ff, scan_idx_in;
   logic [STAMP_W-1:0] q_stamp_ff;
   logic               q_near_ff;
   logic [STAMP_W-1:0] min_gap_ff, min_gap_in;
   logic [STAMP_W-1:0] pick_stamp_ff, pick_stamp_in;
   logic [TAG_W-1:0]   pick_tag_ff, pick_tag_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_found_ff;
   logic [TAG_W-1:0]   rsp_tag_ff;
   logic [STAMP_W-1:0] rsp_stamp_ff;

   // chain
   cell_ctrl_type      chain_ctrl;
   logic [IDXW-1:0]    wr_idx;
   logic [STAMP_W-1:0] front_stamp;
   logic [TAG_W-1:0]   front_tag;

   logic               full;
   logic               drop;
   logic               too_old;
   logic [LIMIT_W-1:0] limit_eff;
   logic               rsp_load;
   logic               found;

   assign full = (count_ff == FULL_CNT);

   // effective limit: 0 or above depth means depth
   assign limit_eff = (limit_ff == '0 || limit_ff > DEPTH_LIM) ? DEPTH_LIM : limit_ff;

   // front entry ages out only when strictly older than the pushed stamp
   assign too_old = (q_stamp_ff > front_stamp) &&
                    ((q_stamp_ff - front_stamp) > window_ff);
   assign drop    = (count_ff != '0) &&
                    (too_old || (LIMIT_W'(count_ff) > limit_eff));

   assign rsp_load = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_tready);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (req_mode == MODE_PUSH) begin
                  state_in = ST_TRIM;
               end else if (req_mode == MODE_NEAR || req_mode == MODE_BEFORE) begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_TRIM: begin
            if (!drop) begin
               state_in = ST_IDLE;
            end
         end
         ST_SCAN: begin
            if (scan_idx_ff == LAST_IDX) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control outputs: chain moves, entry count, scan index
   always_comb begin
      req_tready       = 1'b0;
      chain_ctrl.shift = 1'b0;
      chain_ctrl.load  = 1'b0;
      wr_idx           = count_ff[IDXW-1:0];
      count_in         = count_ff;
      scan_idx_in      = scan_idx_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready  = 1'b1;
            scan_idx_in = '0;
            if (req_accept && req_mode == MODE_PUSH) begin
               chain_ctrl.load = 1'b1;
               if (full) begin
                  // drop oldest and append in one rotation
                  chain_ctrl.shift = 1'b1;
                  wr_idx           = LAST_IDX;
               end else begin
                  count_in = count_ff + CNTW'(1);
               end
            end
         end
         ST_TRIM: begin
            if (drop) begin
               chain_ctrl.shift = 1'b1;
               count_in         = count_ff - CNTW'(1);
            end
         end
         ST_SCAN: begin
            chain_ctrl.shift = 1'b1;
            scan_idx_in      = scan_idx_ff + IDXW'(1);
         end
         ST_FINISH: begin
         end
         default: begin
         end
      endcase
   end

   // scan datapath: cell 0 holds entry scan_idx during ST_SCAN
   always_comb begin
      logic [STAMP_W-1:0] gap;
      logic               live;
      logic               take;
      gap  = (front_stamp > q_stamp_ff) ? (front_stamp - q_stamp_ff)
                                        : (q_stamp_ff - front_stamp);
      live = CNTW'(scan_idx_ff) < count_ff;
      if (q_near_ff) begin
         take = (scan_idx_ff == '0) || (gap < min_gap_ff);
      end else begin
         take = (scan_idx_ff == '0) || (front_stamp <= q_stamp_ff);
      end
      min_gap_in    = min_gap_ff;
      pick_stamp_in = pick_stamp_ff;
      pick_tag_in   = pick_tag_ff;
      if (state_ff == ST_SCAN && live && take) begin
         min_gap_in    = gap;
         pick_stamp_in = front_stamp;
         pick_tag_in   = front_tag;
      end
   end

   assign found = (count_ff != '0) && (!q_near_ff || min_gap_ff <= tolerance_ff);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         scan_idx_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         scan_idx_ff  <= scan_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // configuration registers; unknown index is ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff    <= WINDOW_RESET;
         tolerance_ff <= TOLERANCE_RESET;
         limit_ff     <= LIMIT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_WINDOW:    window_ff    <= csr_wdata;
            CSR_TOLERANCE: tolerance_ff <= csr_wdata;
            CSR_LIMIT:     limit_ff     <= csr_wdata[LIMIT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         q_stamp_ff <= req_stamp;
         q_near_ff  <= (req_mode == MODE_NEAR);
      end
      min_gap_ff    <= min_gap_in;
      pick_stamp_ff <= pick_stamp_in;
      pick_tag_ff   <= pick_tag_in;
      if (rsp_load) begin
         rsp_found_ff <= found;
         rsp_tag_ff   <= found ? pick_tag_ff : '0;
         rsp_stamp_ff <= found ? pick_stamp_ff : '0;
      end
   end

   smfh_chain #(
      .DEPTH (DEPTH),
      .IDXW  (IDXW)
   ) u_chain (
      .clock       (clock),
      .ctrl        (chain_ctrl),
      .wr_idx      (wr_idx),
      .wr_stamp    (req_stamp),
      .wr_tag      (req_tag),
      .front_stamp (front_stamp),
      .front_tag   (front_tag)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_stamp_ff, rsp_tag_ff, rsp_found_ff};

   // check terms
   logic chk_trim_end;
   logic chk_trim_fit;
   logic chk_scan_mid;
   logic chk_in_scan;
   logic chk_miss;
   logic chk_zero;

   assign chk_trim_end = (state_ff == ST_TRIM) && !drop;
   assign chk_trim_fit = LIMIT_W'(count_ff) <= limit_eff;
   assign chk_scan_mid = (state_ff == ST_SCAN) && (scan_idx_ff != LAST_IDX);
   assign chk_in_scan  = (state_ff == ST_SCAN);
   assign chk_miss     = rsp_valid_ff && !rsp_found_ff;
   assign chk_zero     = (rsp_tag_ff == '0) && (rsp_stamp_ff == '0);

   // checks
   `SMFH_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= FULL_CNT, "count above depth")
   `SMFH_ASSERT_NOW(a_trim_done, clock, reset, chk_trim_end, chk_trim_fit, "trim over limit")
   `SMFH_ASSERT_NEXT(a_scan_turn, clock, reset, chk_scan_mid, chk_in_scan, "scan left early")
   `SMFH_ASSERT_NOW(a_miss_zero, clock, reset, chk_miss, chk_zero, "miss carries nonzero match")

endmodule

// ----- rtl/smfh_cell.sv -----
// One storage cell of the history chain: a stamp and a tag.
// Depends on smfh_pkg.
module smfh_cell (
   input  logic                           clock,
   input  smfh_pkg::cell_ctrl_type        ctrl,
   input  logic [smfh_pkg::STAMP_W-1:0]   load_stamp,
   input  logic [smfh_pkg::TAG_W-1:0]     load_tag,
   input  logic [smfh_pkg::STAMP_W-1:0]   nbr_stamp,
   input  logic [smfh_pkg::TAG_W-1:0]     nbr_tag,
   output logic [smfh_pkg::STAMP_W-1:0]   stamp,
   output logic [smfh_pkg::TAG_W-1:0]     tag
);
   import smfh_pkg::*;

   logic [STAMP_W-1:0] stamp_ff;
   logic [TAG_W-1:0]   tag_ff;

   // load wins over the neighbor handoff
   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         stamp_ff <= load_stamp;
         tag_ff   <= load_tag;
      end else if (ctrl.shift) begin
         stamp_ff <= nbr_stamp;
         tag_ff   <= nbr_tag;
      end
   end

   assign stamp = stamp_ff;
   assign tag   = tag_ff;

endmodule

// ----- rtl/smfh_chain.sv -----
// Ring of history cells, oldest entry at cell 0; shift rotates toward cell 0.
// Depends on smfh_pkg and smfh_cell.
module smfh_chain #(
   parameter int DEPTH = 16,
   parameter int IDXW  = 4
) (
   input  logic                           clock,
   input  smfh_pkg::cell_ctrl_type        ctrl,
   input  logic [IDXW-1:0]                wr_idx,
   input  logic [smfh_pkg::STAMP_W-1:0]   wr_stamp,
   input  logic [smfh_pkg::TAG_W-1:0]     wr_tag,
   output logic [smfh_pkg::STAMP_W-1:0]   front_stamp,
   output logic [smfh_pkg::TAG_W-1:0]     front_tag
);
   import smfh_pkg::*;

   logic [STAMP_W-1:0] stamps [DEPTH];
   logic [TAG_W-1:0]   tags   [DEPTH];

   // one cell per entry, each fed by its upper neighbor (wrapping around)
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      localparam int NXT = (i + 1) % DEPTH;
      cell_ctrl_type cc;

      always_comb begin
         cc.shift = ctrl.shift;
         cc.load  = ctrl.load && (wr_idx == IDXW'(i));
      end

      smfh_cell u_cell (
         .clock      (clock),
         .ctrl       (cc),
         .load_stamp (wr_stamp),
         .load_tag   (wr_tag),
         .nbr_stamp  (stamps[NXT]),
         .nbr_tag    (tags[NXT]),
         .stamp      (stamps[i]),
         .tag        (tags[i])
      );
   end

   assign front_stamp = stamps[0];
   assign front_tag   = tags[0];

endmodule
